// ===== sv/vsp_pkg.sv =====
// Shared types and constants for the version string parser.
`timescale 1ns / 1ps

package vsp_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned COMP_W  = 17;
    localparam int unsigned NCOMP   = 3;
    localparam int unsigned PROD_W  = COMP_W + 4;
    localparam int unsigned FIELD_W = NCOMP * COMP_W;
    localparam int unsigned TDATA_W = ((FIELD_W + 7) / 8) * 8;

    localparam logic [CH_W-1:0]   CHAR_NUL  = 8'h00;
    localparam logic [CH_W-1:0]   CHAR_ZERO = 8'h30;
    localparam logic [CH_W-1:0]   CHAR_NINE = 8'h39;
    localparam logic [CH_W-1:0]   CHAR_DOT  = 8'h2E;
    localparam logic [COMP_W-1:0] LIMIT_VALUE = 17'd100000;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_NUM   = 2'd1,
        PH_DOT   = 2'd2
    } phase_t;

    typedef logic [COMP_W-1:0] comp_t;

endpackage

// ===== sv/version_string_parser_unit.sv =====
// Top level of the dotted version string parser.
`timescale 1ns / 1ps

// One character beat is taken every clock cycle; a string of N characters
// takes N beats, and its result appears in the output register on the cycle
// after the beat that ends it (a NUL character or tlast). The rate rests on
// the per-character update of the phase and component accumulators, a
// multiply-by-ten, add and compare done combinationally per beat. The input
// stalls only while a finished result is held and the downstream side is not
// ready. Up to three components are kept; a component above 100000, a stray
// character, a leading or trailing dot, or an empty string gives an all-zero,
// invalid result. Characters after a fourth component begins are ignored.
module version_string_parser_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [vsp_pkg::CH_W-1:0]          s_axis_tdata,  // [7:0] ch
    input  logic                              s_axis_tlast,  // last
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [vsp_pkg::TDATA_W-1:0]       m_axis_tdata,  // major, minor, patch, zero pad
    output logic                              m_axis_tuser   // valid_res
);

    vsp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      count_reg, count_next;
    vsp_pkg::comp_t  vals_reg [vsp_pkg::NCOMP];
    vsp_pkg::comp_t  vals_next [vsp_pkg::NCOMP];
    logic            err_reg, err_next;
    logic            ended_reg, ended_next;

    logic                          out_valid_reg, out_valid_next;
    logic [vsp_pkg::FIELD_W-1:0]   out_data_reg, out_data_next;
    logic                          out_ok_reg, out_ok_next;

    logic                          accept;
    logic                          is_digit;
    logic                          is_nul;
    logic                          finish;
    logic [3:0]                    digit;
    logic [1:0]                    idx;
    vsp_pkg::comp_t                cur_val;
    logic [vsp_pkg::PROD_W-1:0]    grown;
    logic                          ok;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_nul        = (s_axis_tdata == vsp_pkg::CHAR_NUL);
    assign is_digit      = (s_axis_tdata >= vsp_pkg::CHAR_ZERO)
                        && (s_axis_tdata <= vsp_pkg::CHAR_NINE);
    assign digit         = is_digit ? 4'(s_axis_tdata - vsp_pkg::CHAR_ZERO) : 4'd0;
    assign finish        = is_nul || s_axis_tlast;
    assign idx           = count_reg - 2'd1;

    always_comb
    begin
        case (idx)
            2'd0:    cur_val = vals_reg[0];
            2'd1:    cur_val = vals_reg[1];
            2'd2:    cur_val = vals_reg[2];
            default: cur_val = '0;
        endcase
    end

    // value * 10 + digit, as (v << 3) + (v << 1) + d
    assign grown = {1'b0, cur_val, 3'b000}
                 + {3'b000, cur_val, 1'b0}
                 + {{(vsp_pkg::PROD_W-4){1'b0}}, digit};

    // Next-state logic of the character parser
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        err_next   = err_reg;
        ended_next = ended_reg;
        for (int i = 0; i < vsp_pkg::NCOMP; i++)
        begin
            vals_next[i] = vals_reg[i];
        end

        if (!is_nul && !err_reg && !ended_reg)
        begin
            unique case (phase_reg)
                vsp_pkg::PH_NUM:
                begin
                    if (is_digit)
                    begin
                        if (count_reg == 2'd0)
                        begin
                            err_next = 1'b1;
                        end
                        else if (grown > {4'b0000, vsp_pkg::LIMIT_VALUE})
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            vals_next[idx] = grown[vsp_pkg::COMP_W-1:0];
                        end
                    end
                    else if (s_axis_tdata == vsp_pkg::CHAR_DOT)
                    begin
                        phase_next = vsp_pkg::PH_DOT;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    // start, after a dot, or the unused code: a digit opens a component
                    if (is_digit)
                    begin
                        if (count_reg == 2'd3)
                        begin
                            ended_next = 1'b1;
                        end
                        else
                        begin
                            vals_next[count_reg] = {{(vsp_pkg::COMP_W-4){1'b0}}, digit};
                            count_next           = count_reg + 2'd1;
                            phase_next           = vsp_pkg::PH_NUM;
                        end
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            endcase
        end
    end

    assign ok = !err_next && (ended_next || (phase_next == vsp_pkg::PH_NUM));

    // Result register loading
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_ok_next    = out_ok_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept && finish)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = ok;
            out_data_next  = ok ? {vals_next[2], vals_next[1], vals_next[0]} : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= vsp_pkg::PH_START;
            count_reg     <= 2'd0;
            err_reg       <= 1'b0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < vsp_pkg::NCOMP; i++)
            begin
                vals_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                if (finish)
                begin
                    // drop the string state once its result is loaded
                    phase_reg <= vsp_pkg::PH_START;
                    count_reg <= 2'd0;
                    err_reg   <= 1'b0;
                    ended_reg <= 1'b0;
                    for (int i = 0; i < vsp_pkg::NCOMP; i++)
                    begin
                        vals_reg[i] <= '0;
                    end
                end
                else
                begin
                    phase_reg <= phase_next;
                    count_reg <= count_next;
                    err_reg   <= err_next;
                    ended_reg <= ended_next;
                    for (int i = 0; i < vsp_pkg::NCOMP; i++)
                    begin
                        vals_reg[i] <= vals_next[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(vsp_pkg::TDATA_W-vsp_pkg::FIELD_W){1'b0}}, out_data_reg};
    assign m_axis_tuser  = out_ok_reg;

endmodule

// ===== sv/vsp_checker.sv =====
// Port-level assertions for the version string parser, bound to the top level.
`timescale 1ns / 1ps

module vsp_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [vsp_pkg::CH_W-1:0]      s_axis_tdata,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [vsp_pkg::TDATA_W-1:0]   m_axis_tdata,
    input logic                          m_axis_tuser
);

    // a held result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // a beat that ends a string yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
            && (s_axis_tlast || s_axis_tdata == vsp_pkg::CHAR_NUL) |=> m_axis_tvalid)
        else $error("no result after end of string");

    // rejected strings report all-zero components
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("invalid result with nonzero components");

    // components stay within the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[16:0] <= vsp_pkg::LIMIT_VALUE
            && m_axis_tdata[33:17] <= vsp_pkg::LIMIT_VALUE
            && m_axis_tdata[50:34] <= vsp_pkg::LIMIT_VALUE)
        else $error("component above limit");

    // an empty string right after the end of another string never parses as valid
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata == vsp_pkg::CHAR_NUL
            && $past(s_axis_tvalid && s_axis_tready
                     && (s_axis_tlast || s_axis_tdata == vsp_pkg::CHAR_NUL))
            |=> !m_axis_tuser)
        else $error("empty string reported valid");

endmodule

bind version_string_parser_unit vsp_checker u_vsp_checker (.*);
